### sv/spqd_pkg.sv
// ----------------------------------------------------------------------------
// spqd_pkg
// Shared types and codes of the sorted priority queue with duplicate-key
// rejection: the entry record, result status codes and cell control bundle.
// ----------------------------------------------------------------------------
package spqd_pkg;

	localparam int KEY_W  = 32;
	localparam int PRIO_W = 9;
	localparam int TAG_W  = 16;
	localparam int OCC_W  = 7;
	localparam int STAT_W = 3;

	typedef struct packed {
		logic [TAG_W-1:0]  payload;
		logic [PRIO_W-1:0] prio;
		logic [KEY_W-1:0]  key;
	} entry_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_ENQ   = 3'd0,
		STAT_DUP   = 3'd1,
		STAT_DEQ   = 3'd2,
		STAT_EMPTY = 3'd3,
		STAT_FULL  = 3'd4
	} status_t;

	// Broadcast from the controller to every cell of the chain.
	typedef struct packed {
		logic   cmp_en;
		logic   ins_en;
		logic   deq_en;
		entry_t item;
	} cell_ctrl_t;

endpackage

### sv/spqd_cell.sv
// ----------------------------------------------------------------------------
// spqd_cell
// One slot of the sorted chain. It compares its entry against the broadcast
// item and, on a commit, keeps its entry, takes the new item, or takes the
// entry of its left or right neighbor.
// ----------------------------------------------------------------------------
module spqd_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  spqd_pkg::cell_ctrl_t ctrl,
	input  logic                valid,
	input  logic                left_ge,
	input  spqd_pkg::entry_t    left_entry,
	input  spqd_pkg::entry_t    right_entry,
	output spqd_pkg::entry_t    entry,
	output logic                ge,
	output logic                match
);

	spqd_pkg::entry_t entry_q;
	logic             ge_q;
	logic             match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ge_q    <= 1'b0;
			match_q <= 1'b0;
		end else if (ctrl.cmp_en) begin
			ge_q    <= valid && (entry_q.prio >= ctrl.item.prio);
			match_q <= valid && (entry_q.key == ctrl.item.key);
		end
	end

	// The ge flags form a prefix of the chain, so the first cell without the
	// flag is the insertion point and every cell after it shifts right.
	always_ff @(posedge clk) begin
		if (ctrl.deq_en) begin
			entry_q <= right_entry;
		end else if (ctrl.ins_en && !ge_q) begin
			if (left_ge) begin
				entry_q <= ctrl.item;
			end else begin
				entry_q <= left_entry;
			end
		end
	end

	assign entry = entry_q;
	assign ge    = ge_q;
	assign match = match_q;

endmodule

### sv/sorted_priority_queue_dedup_core.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_dedup_core
// Priority queue held in service order in a chain of cells, with rejection
// of enqueues whose key is already stored.
// ----------------------------------------------------------------------------
// Each operation passes through accept, compare and commit states, and a
// new input beat is taken only after the previous operation has committed;
// the commit waits while an earlier result beat is still not taken.
// All cells compare in parallel, so the operation time does not depend on DEPTH.
// Reset clears the entry count, the control state and the output valid;
// the cell contents need no clearing because only filled cells are read.
module sorted_priority_queue_dedup_core #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // entry_key[31:0], priority_req[40:32], payload_tag[56:41], zero
	input  logic [0:0]  s_tuser,  // action[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // out_key[31:0], out_priority[40:32], out_payload[56:41],
	                              // occupancy[63:57]
	output logic [2:0]  m_tuser   // status[2:0]
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_CMP    = 3'b010,
		ST_COMMIT = 3'b100
	} state_t;

	state_t                 state_q;
	logic                   action_q;
	spqd_pkg::entry_t       item_q;
	logic [CNT_W-1:0]       count_q;
	logic                   m_tvalid_q;
	logic [63:0]            m_tdata_q;
	spqd_pkg::status_t      m_status_q;

	spqd_pkg::cell_ctrl_t   ctrl;
	spqd_pkg::entry_t       cell_entry [DEPTH];
	logic [DEPTH-1:0]       ge_vec;
	logic [DEPTH-1:0]       match_vec;

	logic                   commit;
	logic                   is_dup;
	logic                   is_full;
	spqd_pkg::status_t      status_d;
	spqd_pkg::entry_t       out_entry_d;
	logic [CNT_W-1:0]       count_d;

	assign s_tready = (state_q == ST_IDLE);
	assign commit   = (state_q == ST_COMMIT) && (!m_tvalid_q || m_tready);
	assign is_dup   = |match_vec;
	assign is_full  = (count_q == CNT_W'(DEPTH));

	always_comb begin
		status_d    = spqd_pkg::STAT_ENQ;
		out_entry_d = '0;
		count_d     = count_q;
		if (action_q) begin
			if (count_q == '0) begin
				status_d = spqd_pkg::STAT_EMPTY;
			end else begin
				status_d    = spqd_pkg::STAT_DEQ;
				out_entry_d = cell_entry[0];
				count_d     = count_q - 1'b1;
			end
		end else if (is_dup) begin
			status_d = spqd_pkg::STAT_DUP;
		end else if (is_full) begin
			status_d = spqd_pkg::STAT_FULL;
		end else begin
			count_d = count_q + 1'b1;
		end
	end

	always_comb begin
		ctrl.cmp_en = (state_q == ST_CMP);
		ctrl.ins_en = commit && !action_q && !is_dup && !is_full;
		ctrl.deq_en = commit && action_q && (count_q != '0);
		ctrl.item   = item_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (commit) begin
				count_q    <= count_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_q       <= s_tuser[0];
			item_q.key     <= s_tdata[31:0];
			item_q.prio    <= s_tdata[40:32];
			item_q.payload <= s_tdata[56:41];
		end
		if (commit) begin
			m_status_q <= status_d;
			m_tdata_q  <= {spqd_pkg::OCC_W'(count_d), out_entry_d.payload,
			               out_entry_d.prio, out_entry_d.key};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_status_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spqd_pkg::entry_t left_e;
		spqd_pkg::entry_t right_e;
		logic             left_g;

		if (i == 0) begin : g_head
			assign left_e = item_q;
			assign left_g = 1'b1;
		end else begin : g_body
			assign left_e = cell_entry[i-1];
			assign left_g = ge_vec[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_e = cell_entry[i];
		end else begin : g_mid
			assign right_e = cell_entry[i+1];
		end

		spqd_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.valid       (CNT_W'(i) < count_q),
			.left_ge     (left_g),
			.left_entry  (left_e),
			.right_entry (right_e),
			.entry       (cell_entry[i]),
			.ge          (ge_vec[i]),
			.match       (match_vec[i])
		);
	end

	// Keys are unique in the queue, so at most one cell can match.
	a_unique_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("more than one cell matched the key");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds depth");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && status_d == spqd_pkg::STAT_ENQ) |=> (count_q == $past(count_q) + 1'b1))
		else $error("enqueue did not grow the queue by one");

	// The dequeued entry was the head, so its priority is at least that of the new head.
	a_deq_order: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_status_q == spqd_pkg::STAT_DEQ && count_q != '0)
		|-> (m_tdata_q[40:32] >= cell_entry[0].prio))
		else $error("dequeued entry is lower in priority than the head");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted priority queue with duplicate-key
// rejection. Requests go in as stream beats, and every response beat is
// checked against a shadow queue kept in service order.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int QDEPTH = 64;
	localparam int IDLE_LIMIT = 4000;
	localparam logic ACT_ENQ = 1'b0;
	localparam logic ACT_DEQ = 1'b1;

	typedef struct {
		logic             action;
		spqd_pkg::entry_t ent;
		bit               hold;  // wait for all responses before offering this beat
	} request_t;

	typedef struct {
		spqd_pkg::status_t           status;
		logic [spqd_pkg::KEY_W-1:0]  key;
		logic [spqd_pkg::PRIO_W-1:0] prio;
		logic [spqd_pkg::TAG_W-1:0]  payload;
		logic [spqd_pkg::OCC_W-1:0]  occ;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [2:0]  m_tuser;

	request_t         req_fifo[$];
	reply_t           reply_q[$];
	spqd_pkg::entry_t held_entries[$];
	logic [31:0]      recent_keys[$];
	request_t         cur_req;
	int               err_count = 0;
	int               idle_cycles = 0;
	int               gap_left = 0;
	int               burst_left = 0;
	int               rx_mode = 0;
	int               rx_left = 0;

	sorted_priority_queue_dedup_core #(.DEPTH(QDEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Shadow of the queue: apply one accepted request, record the response.
	task automatic apply_request(input request_t r);
		reply_t rep;
		int     pos;
		bit     dup;
		rep.status = spqd_pkg::STAT_ENQ;
		rep.key = '0;
		rep.prio = '0;
		rep.payload = '0;
		dup = 1'b0;
		if (r.action == ACT_DEQ) begin
			if (held_entries.size() == 0) begin
				rep.status = spqd_pkg::STAT_EMPTY;
			end else begin
				rep.status = spqd_pkg::STAT_DEQ;
				rep.key = held_entries[0].key;
				rep.prio = held_entries[0].prio;
				rep.payload = held_entries[0].payload;
				void'(held_entries.pop_front());
			end
		end else begin
			foreach (held_entries[i])
				if (held_entries[i].key == r.ent.key)
					dup = 1'b1;
			if (dup) begin
				rep.status = spqd_pkg::STAT_DUP;
			end else if (held_entries.size() >= QDEPTH) begin
				rep.status = spqd_pkg::STAT_FULL;
			end else begin
				// Equal priorities keep arrival order, so skip past ties.
				pos = 0;
				while (pos < held_entries.size() && held_entries[pos].prio >= r.ent.prio)
					pos++;
				held_entries.insert(pos, r.ent);
			end
		end
		rep.occ = spqd_pkg::OCC_W'(held_entries.size());
		reply_q.push_back(rep);
	endtask

	task automatic add_req(input logic act, input logic [31:0] k, input logic [8:0] p,
			input logic [15:0] t, input bit hold = 1'b0);
		request_t r;
		r.action = act;
		r.ent.key = k;
		r.ent.prio = p;
		r.ent.payload = t;
		r.hold = hold;
		req_fifo.push_back(r);
		if (act == ACT_ENQ) begin
			recent_keys.push_back(k);
			if (recent_keys.size() > 32)
				void'(recent_keys.pop_front());
		end
	endtask

	function automatic logic [31:0] pick_key();
		if (recent_keys.size() > 0 && $urandom_range(0, 3) == 0)
			return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
		return $urandom;
	endfunction

	function automatic logic [8:0] pick_prio();
		// A few common values give plenty of ties.
		case ($urandom_range(0, 5))
			0: return 9'd0;
			1: return 9'd511;
			2: return 9'(100 * $urandom_range(0, 5));
			default: return 9'($urandom_range(0, 511));
		endcase
	endfunction

	task automatic add_mixed(input int count, input int deq_pct, input bit hold_first);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < deq_pct)
				add_req(ACT_DEQ, $urandom, 9'($urandom_range(0, 511)), 16'($urandom),
					hold_first && i == 0);
			else
				add_req(ACT_ENQ, pick_key(), pick_prio(), 16'($urandom),
					hold_first && i == 0);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			err_count++;
		end
	endtask

	// Driver: offer queued requests in bursts separated by random gaps.
	always @(posedge clk) begin : drive_proc
		bit present;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				apply_request(cur_req);
			if (!(s_tvalid && !s_tready)) begin
				present = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (req_fifo.size() > 0 &&
						!(req_fifo[0].hold && (reply_q.size() != 0 || s_tvalid))) begin
					present = 1'b1;
					cur_req = req_fifo.pop_front();
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 20);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
				s_tvalid <= present;
				if (present) begin
					s_tdata <= {7'd0, cur_req.ent.payload, cur_req.ent.prio, cur_req.ent.key};
					s_tuser <= cur_req.action;
				end
			end
		end
	end

	// Receiver: ready pattern switches at random between modes.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(16, 96);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ($urandom_range(0, 7) == 0);
			default: m_tready <= rx_left[1];
		endcase
	end

	always @(posedge clk) begin : check_proc
		reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (reply_q.size() == 0) begin
				$error("unexpected response beat: status %0d, data %0h", m_tuser, m_tdata);
				err_count++;
			end else begin
				want = reply_q.pop_front();
				check_field("status", 32'(want.status), 32'(m_tuser));
				check_field("out_key", want.key, m_tdata[31:0]);
				check_field("out_priority", 32'(want.prio), 32'(m_tdata[40:32]));
				check_field("out_payload", 32'(want.payload), 32'(m_tdata[56:41]));
				check_field("occupancy", 32'(want.occ), 32'(m_tdata[63:57]));
			end
		end
	end

	// Watchdog on cycles with no beat on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		// Directed: empty dequeue, field extremes, ties, duplicates, drain.
		add_req(ACT_DEQ, 32'd0, 9'd0, 16'd0);
		add_req(ACT_ENQ, 32'h0000_0000, 9'd0, 16'h0000);
		add_req(ACT_ENQ, 32'hFFFF_FFFF, 9'd511, 16'hFFFF);
		add_req(ACT_ENQ, 32'h0000_0000, 9'd511, 16'hAAAA);
		add_req(ACT_ENQ, 32'h0000_0001, 9'd511, 16'h5555);
		add_req(ACT_ENQ, 32'h8000_0000, 9'd0, 16'h8001);
		add_req(ACT_ENQ, 32'h5A5A_A5A5, 9'd256, 16'h0F0F);
		add_req(ACT_ENQ, 32'hA5A5_5A5A, 9'd255, 16'hF0F0);
		add_req(ACT_ENQ, 32'hFFFF_FFFF, 9'd1, 16'h1234);
		for (int i = 0; i < 7; i++)
			add_req(ACT_DEQ, 32'hFFFF_FFFF, 9'd511, 16'hFFFF);

		add_mixed(250, 40, 1'b1);

		// Fill past full, retry recently enqueued keys while full, then drain past empty.
		add_req(ACT_ENQ, $urandom, pick_prio(), 16'($urandom), 1'b1);
		for (int i = 0; i < 69; i++)
			add_req(ACT_ENQ, $urandom, pick_prio(), 16'($urandom));
		for (int i = 0; i < 3; i++)
			add_req(ACT_ENQ, recent_keys[$urandom_range(0, recent_keys.size() - 1)],
				pick_prio(), 16'($urandom));
		for (int i = 0; i < 70; i++)
			add_req(ACT_DEQ, $urandom, 9'($urandom_range(0, 511)), 16'($urandom));

		add_mixed(130, 50, 1'b1);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (req_fifo.size() != 0 || s_tvalid || reply_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
